@@ hw/rtl/integer_to_radix_digits_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for integer_to_radix_digits
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

`ifndef SYNTHESIS
`define ITRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itrd same-cycle check failed");
`define ITRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itrd next-cycle check failed");
`else
`define ITRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ITRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/itrd_pkg.sv @@
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants, types and the symbol lookup for the radix converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int ITRD_MAX_RADIX  = 16;
    localparam int ITRD_VALUE_BITS = 32;

    localparam int RADIX_W     = 5;
    localparam int SYM_W       = 64;
    localparam int CHAR_W      = 8;
    localparam int SYM_COUNT   = 16;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 64;
    localparam int REG_SEL_W   = 2;

    localparam logic [REG_SEL_W-1:0] REG_RADIX    = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_SYM_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0]  SYM_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0]  SYM_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  SYM_NONE  = 8'h00;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic last_bit;
        logic negative;
        logic idx_zero;
    } t_status;

    function automatic logic [CHAR_W-1:0] symbol_of(
        input logic [SYM_W-1:0] lo,
        input logic [SYM_W-1:0] hi,
        input logic [3:0]       d
    );
        logic [5:0] pos;
        pos = {d[2:0], 3'b000};
        if (d[3]) begin
            symbol_of = hi[pos +: CHAR_W];
        end else begin
            symbol_of = lo[pos +: CHAR_W];
        end
    endfunction

endpackage

@@ hw/rtl/itrd_regs.sv @@
// ----------------------------------------------------------------------------
// itrd_regs
// APB register file for radix and symbols, with a registered base check.
// ----------------------------------------------------------------------------
module itrd_regs #(
    parameter int MAX_RADIX = itrd_pkg::ITRD_MAX_RADIX
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [itrd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [itrd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [itrd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [itrd_pkg::RADIX_W-1:0]     o_radix,
    output logic [itrd_pkg::SYM_W-1:0]       o_sym_low,
    output logic [itrd_pkg::SYM_W-1:0]       o_sym_high,
    output logic                             o_base_ok
);
    import itrd_pkg::*;

    logic [RADIX_W-1:0]   r_radix;
    logic [SYM_W-1:0]     r_sym_low;
    logic [SYM_W-1:0]     r_sym_high;
    logic                 r_base_ok;
    logic                 n_base_ok;
    logic                 w_wr;
    logic [REG_SEL_W-1:0] w_sel;
    logic [CHAR_W-1:0]    w_sym [SYM_COUNT];

    assign pready = 1'b1;
    assign w_sel  = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_SEL_W];
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        for (int i = 0; i < SYM_COUNT; i++) begin
            w_sym[i] = symbol_of(r_sym_low, r_sym_high, 4'(i));
        end
    end

    always_comb begin
        n_base_ok = (r_radix >= MIN_RADIX) && (r_radix <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (RADIX_W'(i) < r_radix) begin
                if (w_sym[i] == SYM_NONE || w_sym[i] == SYM_PLUS || w_sym[i] == SYM_MINUS) begin
                    n_base_ok = 1'b0;
                end
                for (int j = i + 1; j < SYM_COUNT; j++) begin
                    if (RADIX_W'(j) < r_radix && w_sym[j] == w_sym[i]) begin
                        n_base_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= '0;
            r_sym_low  <= '0;
            r_sym_high <= '0;
            r_base_ok  <= 1'b0;
        end else begin
            r_base_ok <= n_base_ok;
            if (w_wr) begin
                unique case (w_sel)
                    REG_RADIX:    r_radix    <= pwdata[RADIX_W-1:0];
                    REG_SYM_LOW:  r_sym_low  <= pwdata[SYM_W-1:0];
                    REG_SYM_HIGH: r_sym_high <= pwdata[SYM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_RADIX:    prdata = APB_DATA_W'(r_radix);
            REG_SYM_LOW:  prdata = APB_DATA_W'(r_sym_low);
            REG_SYM_HIGH: prdata = APB_DATA_W'(r_sym_high);
            default:      prdata = '0;
        endcase
    end

    assign o_radix    = r_radix;
    assign o_sym_low  = r_sym_low;
    assign o_sym_high = r_sym_high;
    assign o_base_ok  = r_base_ok;

endmodule

@@ hw/rtl/itrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: base check, bit-serial conversion, then sign and digit output.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_assert.svh"

module itrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_base_ok,
    input  itrd_pkg::t_status i_status,
    output logic              o_busy,
    output itrd_pkg::t_cmd    o_cmd
);
    import itrd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_base_ok ? ST_CONV : ST_IDLE;
            end
            ST_CONV: begin
                if (i_status.last_bit) begin
                    n_state = i_status.negative ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (i_status.idx_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy           = (r_state != ST_IDLE);
        o_cmd.load       = (r_state == ST_IDLE) && i_start;
        o_cmd.step       = (r_state == ST_CONV);
        o_cmd.emit_sign  = (r_state == ST_SIGN);
        o_cmd.emit_digit = (r_state == ST_DIGITS);
    end

    `ITRD_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)

endmodule

@@ hw/rtl/itrd_dp.sv @@
// ----------------------------------------------------------------------------
// itrd_dp
// Digit accumulator in the target radix, fed one magnitude bit per cycle,
// and the registered character output.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_assert.svh"

module itrd_dp #(
    parameter int MAX_RADIX  = itrd_pkg::ITRD_MAX_RADIX,
    parameter int VALUE_BITS = itrd_pkg::ITRD_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itrd_pkg::t_cmd                i_cmd,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  logic [itrd_pkg::RADIX_W-1:0]  i_radix,
    input  logic [itrd_pkg::SYM_W-1:0]    i_sym_low,
    input  logic [itrd_pkg::SYM_W-1:0]    i_sym_high,
    output itrd_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic [itrd_pkg::CHAR_W-1:0]   o_out_char,
    output logic                          o_last
);
    import itrd_pkg::*;

    localparam int DIGIT_W = $clog2(MAX_RADIX);
    localparam int RW      = DIGIT_W + 1;
    localparam int NCELL   = VALUE_BITS;
    localparam int CW      = $clog2(NCELL + 1);
    localparam int IW      = $clog2(NCELL);
    localparam int BW      = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [BW-1:0]         r_bits;
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_idx;
    logic [DIGIT_W-1:0]    r_digit [NCELL];
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_last;

    logic [RW-1:0]         w_radix;
    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_abs;
    logic                  w_neg;
    logic [NCELL-1:0]      w_gen;
    logic [NCELL-1:0]      w_prop;
    logic [NCELL-1:0]      w_b;
    logic [NCELL:0]        w_sum;
    logic [NCELL:0]        w_carry;
    logic [RW-1:0]         w_dbl  [NCELL];
    logic [DIGIT_W-1:0]    w_next [NCELL];
    logic                  w_grow;

    assign w_radix = i_radix[RW-1:0];
    assign w_raw   = i_value;
    assign w_neg   = w_raw[VALUE_BITS-1];
    assign w_abs   = w_neg ? (~w_raw + 1'b1) : w_raw;

    always_comb begin
        for (int k = 0; k < NCELL; k++) begin
            w_gen[k]  = ({r_digit[k], 1'b0} >= w_radix);
            w_prop[k] = ({r_digit[k], 1'b1} == w_radix);
        end
    end

    assign w_b     = w_gen | w_prop;
    assign w_sum   = {1'b0, w_gen} + {1'b0, w_b} + (NCELL+1)'(r_mag[VALUE_BITS-1]);
    assign w_carry = {w_sum[NCELL], w_sum[NCELL-1:0] ^ w_gen ^ w_b};
    assign w_grow  = w_carry[r_count];

    always_comb begin
        for (int k = 0; k < NCELL; k++) begin
            w_dbl[k]  = {r_digit[k], w_carry[k]};
            w_next[k] = w_carry[k+1] ? DIGIT_W'(w_dbl[k] - w_radix) : DIGIT_W'(w_dbl[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_bits      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit_sign || i_cmd.emit_digit;
            if (i_cmd.load) begin
                r_mag   <= w_abs;
                r_neg   <= w_neg;
                r_bits  <= BW'(VALUE_BITS - 1);
                r_count <= CW'(1);
                r_idx   <= '0;
            end else if (i_cmd.step) begin
                r_mag  <= r_mag << 1;
                r_bits <= r_bits - 1'b1;
                if (w_grow) begin
                    r_count <= r_count + 1'b1;
                    r_idx   <= r_count[IW-1:0];
                end
            end else if (i_cmd.emit_digit) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < NCELL; k++) begin
                r_digit[k] <= '0;
            end
        end else if (i_cmd.step) begin
            for (int k = 0; k < NCELL; k++) begin
                r_digit[k] <= w_next[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= SYM_MINUS;
            r_last     <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= symbol_of(i_sym_low, i_sym_high, 4'(r_digit[r_idx]));
            r_last     <= (r_idx == '0);
        end
    end

    assign o_status.last_bit = (r_bits == '0);
    assign o_status.negative = r_neg;
    assign o_status.idx_zero = (r_idx == '0);
    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_last            = r_last;

    `ITRD_ASSERT_IMPLIES(a_no_digit_overflow, i_clk, i_rst_n, i_cmd.step, !w_carry[NCELL])
    `ITRD_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_out_valid && o_last, !o_out_valid)
    `ITRD_ASSERT_NEXT(a_chars_contiguous, i_clk, i_rst_n, o_out_valid && !o_last, o_out_valid)

endmodule

@@ hw/rtl/integer_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Signed integer to text in a programmable radix of 2 to 16.
//
//   channel   handshake                       payload
//   input     start, busy                     i_value
//   result    o_out_valid (strobe)            o_out_char, o_last
//   config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// An item passes a base check, then the bit-serial digit accumulator, then
// one character leaves per cycle (sign plus digits). An invalid base ends
// the item with no output.
// Reset is synchronous; no clearing pass. Results cannot be held off.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
    parameter int MAX_RADIX  = itrd_pkg::ITRD_MAX_RADIX,
    parameter int VALUE_BITS = itrd_pkg::ITRD_VALUE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [VALUE_BITS-1:0]     i_value,
    output logic                             o_out_valid,
    output logic [itrd_pkg::CHAR_W-1:0]      o_out_char,
    output logic                             o_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [itrd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [itrd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [itrd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import itrd_pkg::*;

    logic [RADIX_W-1:0] w_radix;
    logic [SYM_W-1:0]   w_sym_low;
    logic [SYM_W-1:0]   w_sym_high;
    logic               w_base_ok;
    t_cmd               w_cmd;
    t_status            w_status;

    itrd_regs #(
        .MAX_RADIX (MAX_RADIX)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_radix    (w_radix),
        .o_sym_low  (w_sym_low),
        .o_sym_high (w_sym_high),
        .o_base_ok  (w_base_ok)
    );

    itrd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_base_ok (w_base_ok),
        .i_status  (w_status),
        .o_busy    (busy),
        .o_cmd     (w_cmd)
    );

    itrd_dp #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .i_radix     (w_radix),
        .i_sym_low   (w_sym_low),
        .i_sym_high  (w_sym_high),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for integer_to_radix_digits
// Programs the radix and the symbol registers over the APB port, sends signed
// values on the start/busy handshake and predicts every emitted character:
// a leading minus for negative values, then the digits of the magnitude,
// most significant first, with last on the final one. Invalid bases must
// emit nothing. Covers directed extremes and broken bases, then random
// bases and values with idle phases on the sender.
// ----------------------------------------------------------------------------
module testbench;
    import itrd_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    class radix_text_scoreboard;
        logic [RADIX_W-1:0] radix;
        logic [SYM_W-1:0]   sym_lo;
        logic [SYM_W-1:0]   sym_hi;
        t_text_char         pending_chars[$];
        int                 errors;

        function new();
            radix  = '0;
            sym_lo = '0;
            sym_hi = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [REG_SEL_W-1:0] idx, logic [SYM_W-1:0] data);
            case (idx)
                REG_RADIX:    radix  = data[RADIX_W-1:0];
                REG_SYM_LOW:  sym_lo = data;
                REG_SYM_HIGH: sym_hi = data;
                default: ;
            endcase
        endfunction

        function logic [CHAR_W-1:0] digit_symbol(int d);
            logic [2*SYM_W-1:0] all_syms;
            all_syms = {sym_hi, sym_lo};
            return all_syms[d*CHAR_W +: CHAR_W];
        endfunction

        function bit base_ok();
            logic [CHAR_W-1:0] s;
            if (radix < MIN_RADIX || radix > ITRD_MAX_RADIX) return 1'b0;
            for (int i = 0; i < radix; i++) begin
                s = digit_symbol(i);
                if (s == SYM_NONE || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
                for (int j = i + 1; j < radix; j++)
                    if (digit_symbol(j) == s) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_value(logic [ITRD_VALUE_BITS-1:0] v);
            logic [ITRD_VALUE_BITS-1:0] mag;
            logic [3:0]                 digits[32];
            int                         count;
            t_text_char                 c;
            if (!base_ok()) return;
            mag = v[ITRD_VALUE_BITS-1] ? -v : v;
            count = 0;
            do begin
                digits[count] = 4'(mag % radix);
                count++;
                mag = mag / radix;
            end while (mag != 0 && count < 32);
            if (v[ITRD_VALUE_BITS-1]) begin
                c.ch   = SYM_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            for (int k = count - 1; k >= 0; k--) begin
                c.ch   = digit_symbol(digits[k]);
                c.last = (k == 0);
                pending_chars.push_back(c);
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_char(logic [CHAR_W-1:0] ch, logic last);
            t_text_char e;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected char %02h last %0b", ch, last));
                return;
            end
            e = pending_chars.pop_front();
            if (ch !== e.ch)
                report($sformatf("out_char %02h, expected %02h", ch, e.ch));
            if (last !== e.last)
                report($sformatf("last %0b, expected %0b", last, e.last));
        endtask
    endclass

    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 420;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [ITRD_VALUE_BITS-1:0] i_value;
    logic                        o_out_valid;
    logic [CHAR_W-1:0]           o_out_char;
    logic                        o_last;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    radix_text_scoreboard sb;
    int                   idle_pct;

    integer_to_radix_digits uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && sb != null) begin
            if (start && !busy) sb.note_value(i_value);
            if (o_out_valid) sb.check_char(o_out_char, o_last);
        end
    end

    task write_reg(logic [REG_SEL_W-1:0] idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= {$urandom, $urandom};
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task set_base(logic [RADIX_W-1:0] r, logic [SYM_W-1:0] lo, logic [SYM_W-1:0] hi);
        logic [APB_DATA_W-1:0] rd;
        rd = {$urandom, $urandom};
        rd[RADIX_W-1:0] = r;
        write_reg(REG_SYM_LOW, lo);
        write_reg(REG_SYM_HIGH, hi);
        write_reg(REG_RADIX, rd);
    endtask

    // drive one value and return at the edge that accepts it, start still high
    task send_value(logic [ITRD_VALUE_BITS-1:0] v);
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task idle_gap();
        while ($urandom_range(99) < idle_pct) begin
            start   <= 1'b0;
            i_value <= $urandom;
            @(posedge i_clk);
        end
    endtask

    task drain();
        start   <= 1'b0;
        i_value <= $urandom;
        @(posedge i_clk);
        while (sb.pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task drain_and_pause();
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_good_base(output logic [RADIX_W-1:0] r,
                                    output logic [2*SYM_W-1:0] all_syms);
        logic [255:0]      used;
        logic [CHAR_W-1:0] s;
        used = '0;
        r = RADIX_W'($urandom_range(ITRD_MAX_RADIX, MIN_RADIX));
        all_syms = {$urandom, $urandom, $urandom, $urandom};
        for (int d = 0; d < r; d++) begin
            do s = CHAR_W'($urandom);
            while (used[s] || s == SYM_NONE || s == SYM_PLUS || s == SYM_MINUS);
            used[s] = 1'b1;
            all_syms[d*CHAR_W +: CHAR_W] = s;
        end
    endtask

    task automatic random_bad_base(output logic [RADIX_W-1:0] r,
                                   output logic [2*SYM_W-1:0] all_syms);
        int i;
        int j;
        random_good_base(r, all_syms);
        case ($urandom_range(3))
            0: begin
                r = RADIX_W'($urandom);
                all_syms = {$urandom, $urandom, $urandom, $urandom};
            end
            1: begin
                i = $urandom_range(r - 1);
                case ($urandom_range(2))
                    0: all_syms[i*CHAR_W +: CHAR_W] = SYM_PLUS;
                    1: all_syms[i*CHAR_W +: CHAR_W] = SYM_MINUS;
                    default: all_syms[i*CHAR_W +: CHAR_W] = SYM_NONE;
                endcase
            end
            2: begin
                i = $urandom_range(r - 1);
                do j = $urandom_range(r - 1); while (j == i);
                all_syms[j*CHAR_W +: CHAR_W] = all_syms[i*CHAR_W +: CHAR_W];
            end
            default: begin
                if ($urandom_range(1)) r = RADIX_W'($urandom_range(1));
                else r = RADIX_W'($urandom_range(31, ITRD_MAX_RADIX + 1));
            end
        endcase
    endtask

    function automatic logic [ITRD_VALUE_BITS-1:0] random_value(int r);
        longint p;
        int     steps;
        logic [ITRD_VALUE_BITS-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            1, 2: v = $urandom_range(r * r * r);
            3, 4: begin
                p = 1;
                steps = $urandom_range(31, 1);
                for (int k = 0; k < steps && p * r <= 64'h8000_0000; k++) p = p * r;
                v = ITRD_VALUE_BITS'(p - $urandom_range(1));
            end
            default: v = $urandom;
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [RADIX_W-1:0]   r;
        logic [2*SYM_W-1:0]   all_syms;
        int                   good_items;
        int                   n;
        bit                   good;

        sb = new();
        idle_pct = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_value <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // radix zero after reset: nothing comes out
        send_value(32'd0);
        send_value(32'hFFFF_FFFB);
        drain_and_pause();

        set_base(5'd10, 64'h3736_3534_3332_3130, 64'h002B_2D41_4243_3938);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1_000_000_000);
        send_value(32'hFFFF_FFF7);
        drain_and_pause();

        set_base(5'd2, 64'h2D2B_00FF_EEDD_3130, 64'h0);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFFFF_FFFF);
        drain_and_pause();

        set_base(5'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hDEAD_BEEF);
        send_value(32'd0);
        send_value(32'd16);
        drain_and_pause();

        // broken bases
        set_base(5'd16, 64'h3736_3534_3332_3130, 64'h2B65_6463_6261_3938);
        send_value(32'd255);
        drain_and_pause();
        set_base(5'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3930);
        send_value(32'd99);
        drain_and_pause();
        set_base(5'd3, 64'h0000_0000_0000_3130, 64'h0);
        send_value(32'd5);
        drain_and_pause();
        set_base(5'd4, 64'h0000_0000_2D32_3130, 64'h0);
        send_value(32'd7);
        drain_and_pause();
        set_base(5'd17, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
        send_value(32'd17);
        drain_and_pause();
        set_base(5'd1, 64'h3736_3534_3332_3130, 64'h0);
        send_value(32'd1);
        drain_and_pause();

        good_items = 0;
        for (int phase = 0; good_items < RANDOM_ITEMS; phase++) begin
            good = ($urandom_range(99) < 85);
            if (good) random_good_base(r, all_syms);
            else random_bad_base(r, all_syms);
            set_base(r, all_syms[SYM_W-1:0], all_syms[2*SYM_W-1:SYM_W]);
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 88;
                default: idle_pct = 35;
            endcase
            good = sb.base_ok();
            n = good ? $urandom_range(40, 20) : 3;
            for (int i = 0; i < n; i++) begin
                if (i == n / 2) drain();
                send_value(random_value(r < MIN_RADIX ? MIN_RADIX : r));
                if (good) good_items++;
                idle_gap();
            end
            drain_and_pause();
        end

        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
